@@ rtl/core/clsr_pkg.sv @@
// Shared constants and codes for the combined LCG / shuffle-table generator.
// No dependencies; every other file in rtl/core imports this package.
package clsr_pkg;

  localparam int DATA_W = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = DATA_W + MUL_W;

  // Generator moduli and multipliers.
  localparam logic [31:0]       MOD_A = 32'd2147483563;
  localparam logic [31:0]       MOD_B = 32'd2147483399;
  localparam logic [MUL_W-1:0]  MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_B = 16'd40692;

  // 2^31 mod M for each modulus: folds the high product bits back down.
  localparam logic [31:0] FOLD_A = 32'd85;
  localparam logic [31:0] FOLD_B = 32'd249;

  localparam logic [DATA_W-1:0] SPAN_MAX    = 31'd2147483562;
  localparam logic [DATA_W-1:0] GEN_A_INIT  = 31'd1;
  localparam logic [DATA_W-1:0] GEN_B_INIT  = 31'd123456789;

  localparam int TABLE_SIZE_DEF = 32;
  localparam int WARMUP_EXTRA   = 8;

  // Operation codes.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

endpackage

@@ rtl/core/clsr_if.sv @@
// Valid/ready channel interfaces for the generator: request and result.
// Depends on clsr_pkg for field widths.
interface clsr_req_if import clsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [DATA_W-1:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface clsr_rsp_if import clsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

@@ rtl/core/combined_lcg_shuffle_rng_unit.sv @@
// Combined two-modulus LCG with a shuffle table, one result beat per request beat.
// Draw: accept moves to DRD, the table read lands in DFIN, then the result is registered;
// a new draw can be accepted in DFIN as the previous one finishes. Reseed: the
// warm-up loop through the two-stage modular step unit runs first, then the draw.
// Synchronous active-high rst: generators to 1 and 123456789, last output to 0,
// table valid bits cleared (unwritten entries read as 0). No clearing pass.
module combined_lcg_shuffle_rng_unit import clsr_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  clsr_req_if.sink    req,
  clsr_rsp_if.source  rsp
);

  localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int WARM_LAST = TABLE_SIZE + WARMUP_EXTRA - 1;
  localparam int CNT_W     = $clog2(WARM_LAST + 1);
  // slot width: table index = last_output / SLOT_DIV
  localparam longint SLOT_DIV = 64'd1 + (longint'(SPAN_MAX) / TABLE_SIZE);

  // Sequencer states. WMUL/DMUL wait for the product register.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WMUL = 6'b000010,
    ST_WRED = 6'b000100,
    ST_DMUL = 6'b001000,
    ST_DRD  = 6'b010000,
    ST_DFIN = 6'b100000
  } state_t;

  state_t            state;
  logic [DATA_W-1:0] x;            // first generator
  logic [DATA_W-1:0] y;            // second generator
  logic [DATA_W-1:0] last_output;
  logic [CNT_W-1:0]  cnt;          // warm-up step, counts down to 0
  logic [IDX_W-1:0]  rd_idx;       // entry picked by the draw in flight
  logic              out_valid;
  logic [DATA_W-1:0] out_data;

  logic [DATA_W-1:0] red_a;
  logic [DATA_W-1:0] red_b;
  logic [DATA_W-1:0] entry;
  logic [IDX_W-1:0]  slot_idx;
  logic [DATA_W-1:0] draw_out;
  logic [DATA_W-1:0] seed_clamped;
  logic              fin_go;
  logic              accept;
  logic              tbl_rd_en;
  logic              tbl_wr_en;
  logic [IDX_W-1:0]  tbl_wr_addr;
  logic [DATA_W-1:0] tbl_wr_data;

  // ---------------------------------------------------------------------
  // Modular step unit. Its product register always follows x/y of the
  // previous cycle, so x/y must be held for the product register before a fold.
  // ---------------------------------------------------------------------
  clsr_step u_step (
    .clk    (clk),
    .a_cur  (x),
    .b_cur  (y),
    .a_next (red_a),
    .b_next (red_b)
  );

  // ---------------------------------------------------------------------
  // Shuffle table. Draw reads in DRD, writes back in DFIN; the next read
  // is in a later DRD, after the write, so no same-entry overlap needs forwarding.
  // ---------------------------------------------------------------------
  clsr_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tbl_rd_en),
    .rd_addr (slot_idx),
    .rd_data (entry),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  // Index = last_output / SLOT_DIV as a thermometer of constant thresholds.
  // Never exceeds TABLE_SIZE-1, so no saturation is needed.
  always_comb begin
    slot_idx = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if (32'(last_output) >= 32'(longint'(k) * SLOT_DIV)) begin
        slot_idx = slot_idx + IDX_W'(1);
      end
    end
  end

  // Draw result: entry - y, wrapped by SPAN_MAX when not positive.
  always_comb begin
    if (entry > y) begin
      draw_out = entry - y;
    end else begin
      draw_out = entry - y + SPAN_MAX;
    end
  end

  assign seed_clamped = (req.seed_value == '0) ? GEN_A_INIT : req.seed_value;

  // Finish a draw only when the output register is free or draining.
  assign fin_go    = (state == ST_DFIN) && (!out_valid || rsp.ready);
  assign req.ready = !rst && ((state == ST_IDLE) || fin_go);
  assign accept    = req.valid && req.ready;

  assign tbl_rd_en   = (state == ST_DRD);
  assign tbl_wr_en   = ((state == ST_WRED) && (cnt < CNT_W'(TABLE_SIZE))) || fin_go;
  assign tbl_wr_addr = (state == ST_WRED) ? cnt[IDX_W-1:0] : rd_idx;
  assign tbl_wr_data = (state == ST_WRED) ? red_a : x;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      x           <= GEN_A_INIT;
      y           <= GEN_B_INIT;
      last_output <= '0;
      cnt         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        ST_WMUL: begin
          state <= ST_WRED;
        end
        ST_WRED: begin
          x <= red_a;
          if (cnt == '0) begin
            // final warm-up value also lands in entry 0
            last_output <= red_a;
            state       <= ST_DMUL;
          end else begin
            cnt   <= cnt - CNT_W'(1);
            state <= ST_WMUL;
          end
        end
        ST_DMUL: begin
          state <= ST_DRD;
        end
        ST_DRD: begin
          x      <= red_a;
          y      <= red_b;
          rd_idx <= slot_idx;
          state  <= ST_DFIN;
        end
        ST_DFIN: begin
          if (fin_go) begin
            last_output <= draw_out;
            // a beat taken on the same edge picks the next state below
            if (!accept) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // new beat: from IDLE, or back to back with a finishing draw
      if (accept) begin
        if (req.operation == OP_RESEED) begin
          x     <= seed_clamped;
          y     <= seed_clamped;
          cnt   <= CNT_W'(WARM_LAST);
          state <= ST_WMUL;
        end else begin
          state <= ST_DRD;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data <= draw_out;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_data;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.random_value != '0 && rsp.random_value <= SPAN_MAX))
    else $error("result beat out of range");

  a_gen_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DFIN) |-> (32'(x) < MOD_A && 32'(y) < MOD_B))
    else $error("generator not reduced after step");

  a_fin_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DFIN) |-> ($past(state) == ST_DRD || $past(state) == ST_DFIN))
    else $error("draw finish without table read");

  a_warm_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DMUL) |-> ($past(state) == ST_WRED && last_output == x))
    else $error("warm-up end did not load last output");

endmodule

@@ rtl/core/clsr_step.sv @@
// Two-stage modular step for both generators: registered product, then fold.
// Depends on clsr_pkg.
module clsr_step import clsr_pkg::*; (
  input  logic              clk,
  input  logic [DATA_W-1:0] a_cur,
  input  logic [DATA_W-1:0] b_cur,
  output logic [DATA_W-1:0] a_next,
  output logic [DATA_W-1:0] b_next
);

  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic [31:0]       sum_a;
  logic [31:0]       sum_b;

  // product of whatever the generator held last cycle
  always_ff @(posedge clk) begin
    prod_a <= PROD_W'(a_cur) * PROD_W'(MUL_A);
    prod_b <= PROD_W'(b_cur) * PROD_W'(MUL_B);
  end

  // hi*2^31 + lo == hi*fold + lo (mod M); sum < 2M so one subtract finishes it
  always_comb begin
    sum_a = 32'(prod_a[DATA_W-1:0]) + 32'(prod_a[PROD_W-1:DATA_W]) * FOLD_A;
    sum_b = 32'(prod_b[DATA_W-1:0]) + 32'(prod_b[PROD_W-1:DATA_W]) * FOLD_B;
    a_next = (sum_a >= MOD_A) ? DATA_W'(sum_a - MOD_A) : DATA_W'(sum_a);
    b_next = (sum_b >= MOD_B) ? DATA_W'(sum_b - MOD_B) : DATA_W'(sum_b);
  end

endmodule

@@ rtl/core/clsr_table.sv @@
// Shuffle table: synchronous single-write / single-read memory, registered read.
// Per-entry valid flops make unwritten entries read as zero. Depends on clsr_pkg.
module clsr_table import clsr_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int IDX_W      = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0]     mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] filled;
  logic [DATA_W-1:0]     rd_q;
  logic                  rd_filled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_filled <= filled[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_filled ? rd_q : '0;

endmodule

@@ sim/combined_lcg_shuffle_rng_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for combined_lcg_shuffle_rng_unit: a directed table, then random reseed/draw bursts.
// Every result beat is checked against a local model of the two generators and the shuffle table, or a typed row value.
// Depends on clsr_pkg, clsr_if and the unit itself.
module combined_lcg_shuffle_rng_unit_tb;
  import clsr_pkg::*;

  localparam int          TBL        = TABLE_SIZE_DEF;
  localparam int unsigned SLOT_DIV   = 1 + int'(SPAN_MAX) / TBL;
  localparam int          RANDOM_REQ = 800;
  // Longest quiet stretch of a correct run is a reseed or the long
  // receiver hold-off below; the limit sits well above both.
  localparam int          QUIET_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 120;

  logic clk;
  logic rst;

  clsr_req_if req_ch ();
  clsr_rsp_if rsp_ch ();

  combined_lcg_shuffle_rng_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Generator model: both LCGs, the last output and the shuffle table.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] gen_a;
  logic [DATA_W-1:0] gen_b;
  logic [DATA_W-1:0] last_value;
  logic [DATA_W-1:0] shuffle_tbl [TBL];

  logic [DATA_W-1:0] pending_values [$];
  int                fail_count;

  function automatic logic [DATA_W-1:0] lcg_a_next(input logic [DATA_W-1:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(MUL_A);
    return DATA_W'(prod % 64'(MOD_A));
  endfunction

  function automatic logic [DATA_W-1:0] lcg_b_next(input logic [DATA_W-1:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(MUL_B);
    return DATA_W'(prod % 64'(MOD_B));
  endfunction

  // Advances the model by one request beat and returns the random value it yields.
  function automatic logic [DATA_W-1:0] predict_random_value(input logic op,
                                                             input logic [DATA_W-1:0] seed);
    logic [DATA_W-1:0] s;
    int unsigned       slot;
    longint            diff;
    if (op == OP_RESEED) begin
      // seed of zero is clamped to one; warm-up runs TBL+8 steps of gen_a only,
      // the last TBL of them filling the table from the top down to entry 0
      s = (seed == '0) ? DATA_W'(1) : seed;
      gen_a = s;
      gen_b = s;
      for (int n = TBL + WARMUP_EXTRA - 1; n >= 0; n--) begin
        gen_a = lcg_a_next(gen_a);
        if (n < TBL) shuffle_tbl[n] = gen_a;
      end
      last_value = shuffle_tbl[0];
    end
    gen_a = lcg_a_next(gen_a);
    gen_b = lcg_b_next(gen_b);
    slot = int'(last_value) / SLOT_DIV;
    if (slot >= TBL) slot = TBL - 1;
    diff = longint'(shuffle_tbl[slot]) - longint'(gen_b);
    shuffle_tbl[slot] = gen_a;
    if (diff < 1) diff += longint'(SPAN_MAX);
    last_value = DATA_W'(diff);
    return last_value;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. A beat is predicted the moment it is accepted.
  // ---------------------------------------------------------------------------
  int send_idle_pct;
  int rcv_idle_pct;
  bit hold_off_req;

  task automatic send_request(input logic op, input logic [DATA_W-1:0] seed,
                              input bit typed, input logic [DATA_W-1:0] typed_value);
    logic [DATA_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_random_value(op, seed);
    pending_values.push_back(typed ? typed_value : predicted);
  endtask

  // Seeds lean toward the interesting corners: tiny, the moduli, the top of the field.
  function automatic logic [DATA_W-1:0] pick_seed();
    case ($urandom_range(9))
      0:       return DATA_W'($urandom_range(3));
      1:       return DATA_W'(MOD_A) - DATA_W'(2) + DATA_W'($urandom_range(4));
      2:       return DATA_W'(MOD_B) - DATA_W'(2) + DATA_W'($urandom_range(4));
      3:       return {DATA_W{1'b1}} - DATA_W'($urandom_range(3));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // A reseed followed by a run of draws with junk in the seed field.
  task automatic send_burst(inout int sent);
    int run_len;
    run_len = $urandom_range(12);
    send_request(OP_RESEED, pick_seed(), 1'b0, '0);
    sent++;
    for (int k = 0; k < run_len; k++) begin
      send_request(OP_DRAW, DATA_W'($urandom), 1'b0, '0);
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: reset-state draws, seed clamp, seeds at and next to both
  // moduli (a multiple of a modulus parks that generator at zero), top seed.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic              op;
    logic [DATA_W-1:0] seed;
    bit                typed;
    logic [DATA_W-1:0] value;
  } stim_row_t;

  localparam int N_DIRECTED = 22;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // first draw from reset: table entry 0 is zero, so the result wraps by SPAN_MAX
    '{OP_DRAW,   31'd0,          1'b1, 31'd1407495835},
    '{OP_DRAW,   31'h7FFF_FFFF,  1'b0, 31'd0},
    '{OP_RESEED, 31'd0,          1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_RESEED, 31'd1,          1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_RESEED, 31'h7FFF_FFFF,  1'b0, 31'd0},
    '{OP_DRAW,   31'h5555_5555,  1'b0, 31'd0},
    '{OP_RESEED, 31'd2147483563, 1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_RESEED, 31'd2147483399, 1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_RESEED, 31'd2147483562, 1'b0, 31'd0},
    '{OP_RESEED, 31'd2147483398, 1'b0, 31'd0},
    '{OP_DRAW,   31'h2AAA_AAAA,  1'b0, 31'd0},
    '{OP_RESEED, 31'h4000_0000,  1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0},
    '{OP_RESEED, 31'd2,          1'b0, 31'd0},
    '{OP_DRAW,   31'd0,          1'b0, 31'd0}
  };

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus one long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Result check and quiet-cycle watchdog.
  initial begin
    int               quiet;
    logic [DATA_W-1:0] want;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
          if (pending_values.size() == 0) begin
            $error("random_value: no beat expected, actual %0d", rsp_ch.random_value);
            fail_count++;
          end else begin
            want = pending_values.pop_front();
            if (rsp_ch.random_value !== want) begin
              $error("random_value: expected %0d, actual %0d", want, rsp_ch.random_value);
              fail_count++;
            end
          end
        end
        if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    fail_count    = 0;
    hold_off_req  = 1'b0;
    send_idle_pct = 20;
    rcv_idle_pct  = 77;
    gen_a         = GEN_A_INIT;
    gen_b         = GEN_B_INIT;
    last_value    = '0;
    foreach (shuffle_tbl[i]) shuffle_tbl[i] = '0;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_DRAW;
    req_ch.seed_value = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // phase 0: sender idles lightly, receiver heavily
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].seed,
                   directed_rows[i].typed, directed_rows[i].value);
    sent = 0;
    while (sent < RANDOM_REQ / 3) send_burst(sent);

    // phase 1: swapped
    send_idle_pct = 77;
    rcv_idle_pct  = 20;
    while (sent < 2 * RANDOM_REQ / 3) send_burst(sent);

    // phase 2: no idling; a long receiver hold-off first so the unit backs up
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    hold_off_req  = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_request(OP_DRAW, DATA_W'($urandom), 1'b0, '0);
      sent++;
    end
    while (sent < RANDOM_REQ) send_burst(sent);
    req_ch.valid <= 1'b0;

    while (pending_values.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
